>>> hw/rtl/gbs_pkg.sv
// Package: widths, register indexes, parameter defaults and control/status types.
`default_nettype none
package gbs_pkg;

  localparam int ADDR_W    = 32;
  localparam int IDX_W     = 12;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STOP  = 2'd2;

  localparam logic KIND_ADDR  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  localparam int WORD_BITS_DEF    = 32;
  localparam int OBJECT_ALIGN_DEF = 8;
  localparam int BATCH_SLOTS_DEF  = 128;
  localparam int BITMAP_WORDS_DEF = 4096;

  typedef struct packed {
    logic capture;
    logic eval;
    logic emit_addr;
    logic emit_close;
    logic last;
  } gbs_cmd_t;

  typedef struct packed {
    logic chk_in_range;
    logic chk_garbage;
    logic chk_close;
    logic one_left;
    logic close_after;
    logic out_free;
  } gbs_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/gbs_if.sv
// Channel interfaces: input word, result and configuration write.
`default_nettype none
interface gbs_in_if;
  logic                      valid;
  logic                      ready;
  logic [gbs_pkg::IDX_W-1:0]  word_index;
  logic [gbs_pkg::DATA_W-1:0] live_bits;
  logic [gbs_pkg::DATA_W-1:0] marked_bits;

  modport source(output valid, word_index, live_bits, marked_bits, input ready);
  modport sink(input valid, word_index, live_bits, marked_bits, output ready);
endinterface

interface gbs_out_if;
  logic                       valid;
  logic                       ready;
  logic                       result_kind;
  logic [gbs_pkg::ADDR_W-1:0]  object_address;
  logic [gbs_pkg::COUNT_W-1:0] batch_count;
  logic                       last_of_item;

  modport source(output valid, result_kind, object_address, batch_count, last_of_item,
                 input ready);
  modport sink(input valid, result_kind, object_address, batch_count, last_of_item,
               output ready);
endinterface

interface gbs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [gbs_pkg::CFG_IDX_W-1:0] index;
  logic [gbs_pkg::DATA_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/gbs_ctrl.sv
// Controller: sequences capture, range check, address emission and batch close.
`default_nettype none
module gbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gbs_pkg::gbs_sts_t sts,
  output gbs_pkg::gbs_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT,
    S_CLOSE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.eval = 1'b1;
        if (!sts.chk_in_range) begin
          state_nxt = S_IDLE;
        end else if (sts.chk_garbage) begin
          state_nxt = S_EMIT;
        end else if (sts.chk_close) begin
          state_nxt = S_CLOSE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_addr = 1'b1;
          cmd.last      = sts.one_left && !sts.close_after;
          if (sts.one_left) begin
            state_nxt = sts.close_after ? S_CLOSE : S_IDLE;
          end
        end
      end
      S_CLOSE: begin
        if (sts.out_free) begin
          cmd.emit_close = 1'b1;
          cmd.last       = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/gbs_datapath.sv
// Datapath: config registers, range check, garbage word, batch fill and result register.
`default_nettype none
module gbs_datapath #(
  parameter int WORD_BITS    = gbs_pkg::WORD_BITS_DEF,
  parameter int OBJECT_ALIGN = gbs_pkg::OBJECT_ALIGN_DEF,
  parameter int BATCH_SLOTS  = gbs_pkg::BATCH_SLOTS_DEF,
  parameter int BITMAP_WORDS = gbs_pkg::BITMAP_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gbs_pkg::IDX_W-1:0]     in_word_index,
  input  logic [gbs_pkg::DATA_W-1:0]    in_live_bits,
  input  logic [gbs_pkg::DATA_W-1:0]    in_marked_bits,
  input  logic                          cfg_we,
  input  logic [gbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbs_pkg::DATA_W-1:0]    cfg_data,
  input  gbs_pkg::gbs_cmd_t             cmd,
  output gbs_pkg::gbs_sts_t             sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_result_kind,
  output logic [gbs_pkg::ADDR_W-1:0]    out_object_address,
  output logic [gbs_pkg::COUNT_W-1:0]   out_batch_count,
  output logic                          out_last_of_item
);

  localparam int AW     = gbs_pkg::ADDR_W;
  localparam int GRAN   = OBJECT_ALIGN * WORD_BITS;
  localparam int GRAN_W = $clog2(GRAN + 1);
  localparam int PROD_W = gbs_pkg::IDX_W + GRAN_W + 1;
  localparam int LIM_W  = $clog2(BITMAP_WORDS + 1) + GRAN_W;
  localparam int CMP_A  = (PROD_W > LIM_W) ? PROD_W : LIM_W;
  localparam int CMP_W  = (CMP_A > AW + 1) ? CMP_A : AW + 1;
  localparam int POS_W  = $clog2(WORD_BITS);
  localparam int THRESH = (BATCH_SLOTS > WORD_BITS) ? BATCH_SLOTS - WORD_BITS : 0;
  localparam int FILL_W = $clog2(BATCH_SLOTS + WORD_BITS + 1);

  localparam logic [CMP_W-1:0]  LIMIT    = CMP_W'(BITMAP_WORDS) * CMP_W'(GRAN);
  localparam logic [CMP_W-1:0]  GRAN_C   = CMP_W'(GRAN);
  localparam logic [FILL_W-1:0] THRESH_C = FILL_W'(THRESH);

  logic [AW-1:0] heap_base_r, sweep_start_r, sweep_stop_r;
  logic [AW-1:0] dstart_r, dstop1_r;
  logic          bad_r;

  logic [CMP_W-1:0]     prod_r, prod1_r;
  logic [WORD_BITS-1:0] live_r, marked_r;

  logic [WORD_BITS-1:0] garbage_r;
  logic [AW-1:0]        base_r;
  logic                 is_last_r;
  logic [FILL_W-1:0]    fill_r;

  logic                 out_valid_r, out_kind_r, out_last_r;
  logic [AW-1:0]        out_addr_r;
  logic [gbs_pkg::COUNT_W-1:0] out_count_r;

  logic [WORD_BITS-1:0] garbage_chk;
  logic                 lo_ok, hi_ok, last_eq, in_range;
  logic [WORD_BITS-1:0] lead_mask;
  logic [POS_W-1:0]     lead_pos;
  logic [FILL_W-1:0]    fill_inc;
  logic [AW-1:0]        addr_nxt;
  logic [CMP_W-1:0]     prod_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r   <= '0;
      sweep_start_r <= '0;
      sweep_stop_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbs_pkg::CFG_HEAP_BASE:   heap_base_r   <= cfg_data;
        gbs_pkg::CFG_SWEEP_START: sweep_start_r <= cfg_data;
        gbs_pkg::CFG_SWEEP_STOP:  sweep_stop_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // precompute range offsets from settled config
  always_ff @(posedge clk) begin
    dstart_r <= sweep_start_r - heap_base_r;
    dstop1_r <= sweep_stop_r - heap_base_r - AW'(1);
    bad_r    <= (sweep_stop_r <= sweep_start_r) || (sweep_start_r < heap_base_r) ||
                !(CMP_W'(sweep_stop_r - heap_base_r - AW'(1)) < LIMIT);
  end

  assign prod_nxt = CMP_W'(in_word_index) * GRAN_C;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      prod_r   <= prod_nxt;
      prod1_r  <= prod_nxt + GRAN_C;
      live_r   <= WORD_BITS'(in_live_bits);
      marked_r <= WORD_BITS'(in_marked_bits);
    end
  end

  assign garbage_chk = live_r & ~marked_r;
  assign lo_ok       = prod1_r > CMP_W'(dstart_r);
  assign hi_ok       = prod_r <= CMP_W'(dstop1_r);
  assign last_eq     = hi_ok && (prod1_r > CMP_W'(dstop1_r));
  assign in_range    = !bad_r && lo_ok && hi_ok;

  always_comb begin
    lead_mask = '0;
    lead_pos  = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (garbage_r[b]) begin
        lead_mask = '0;
        lead_mask[b] = 1'b1;
        lead_pos  = POS_W'(WORD_BITS - 1 - b);
      end
    end
  end

  assign fill_inc = fill_r + FILL_W'(1);
  assign addr_nxt = base_r + AW'(lead_pos) * AW'(OBJECT_ALIGN);

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      is_last_r <= last_eq;
      base_r    <= heap_base_r + AW'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      garbage_r <= garbage_chk;
    end else if (cmd.emit_addr) begin
      garbage_r <= garbage_r & ~lead_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.emit_close) begin
      fill_r <= '0;
    end else if (cmd.emit_addr) begin
      fill_r <= fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_addr || cmd.emit_close) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_addr) begin
      out_kind_r  <= gbs_pkg::KIND_ADDR;
      out_addr_r  <= addr_nxt;
      out_count_r <= '0;
      out_last_r  <= cmd.last;
    end else if (cmd.emit_close) begin
      out_kind_r  <= gbs_pkg::KIND_CLOSE;
      out_addr_r  <= '0;
      out_count_r <= gbs_pkg::COUNT_W'(fill_r);
      out_last_r  <= cmd.last;
    end
  end

  always_comb begin
    sts.chk_in_range = in_range;
    sts.chk_garbage  = garbage_chk != '0;
    sts.chk_close    = last_eq && (fill_r != '0);
    sts.one_left     = (garbage_r & ~lead_mask) == '0;
    sts.close_after  = (fill_inc >= THRESH_C) || is_last_r;
    sts.out_free     = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_object_address = out_addr_r;
  assign out_batch_count    = out_count_r;
  assign out_last_of_item   = out_last_r;

endmodule
`default_nettype wire

>>> hw/rtl/gc_bitmap_sweep_emitter.sv
// Top level: bitmap sweep emitter, controller plus datapath.
// An accepted word goes through capture and range check only when it yields no result.
// A word emits one address per garbage bit, plus a batch close when it closes a batch;
// the emit path loads a single address per cycle into the result register, unless stalled.
// First result path: check state, emit state, result register; output stalls delay it.
// Synchronous active-low reset clears config registers, batch fill, state and out valid.
`default_nettype none
module gc_bitmap_sweep_emitter #(
  parameter int WORD_BITS    = gbs_pkg::WORD_BITS_DEF,
  parameter int OBJECT_ALIGN = gbs_pkg::OBJECT_ALIGN_DEF,
  parameter int BATCH_SLOTS  = gbs_pkg::BATCH_SLOTS_DEF,
  parameter int BITMAP_WORDS = gbs_pkg::BITMAP_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gbs_in_if.sink    in_ch,
  gbs_out_if.source out_ch,
  gbs_cfg_if.sink   cfg_ch
);

  gbs_pkg::gbs_cmd_t cmd;
  gbs_pkg::gbs_sts_t sts;
  logic              in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  gbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbs_datapath #(
    .WORD_BITS    (WORD_BITS),
    .OBJECT_ALIGN (OBJECT_ALIGN),
    .BATCH_SLOTS  (BATCH_SLOTS),
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_word_index      (in_ch.word_index),
    .in_live_bits       (in_ch.live_bits),
    .in_marked_bits     (in_ch.marked_bits),
    .cfg_we             (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_result_kind    (out_ch.result_kind),
    .out_object_address (out_ch.object_address),
    .out_batch_count    (out_ch.batch_count),
    .out_last_of_item   (out_ch.last_of_item)
  );

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_addr || cmd.emit_close) |-> (!out_ch.valid || out_ch.ready))
    else $error("result loaded while output register is held");

  a_emit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_addr && cmd.emit_close))
    else $error("address and close emitted in the same cycle");

  a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> !(cmd.emit_addr || cmd.emit_close || cmd.eval))
    else $error("input captured while a word is in progress");

  a_close_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_addr && !cmd.last && sts.one_left) |=> !in_ready)
    else $error("input accepted before batch close was emitted");

endmodule
`default_nettype wire
